// ===== src/adcrr_pkg.sv =====
// ----------------------------------------------------------------------------
// adcrr_pkg
// Types and constants shared by the ADC controller front end, request queue
// and register back end.
// ----------------------------------------------------------------------------
`default_nettype none

package adcrr_pkg;

  // bus op codes as they arrive on the input channel
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  // register byte offsets
  localparam logic [5:0] OFF_CS     = 6'd0;
  localparam logic [5:0] OFF_RESULT = 6'd4;
  localparam logic [5:0] OFF_FCS    = 6'd8;
  localparam logic [5:0] OFF_FIFO   = 6'd12;
  localparam logic [5:0] OFF_DIV    = 6'd16;
  localparam logic [5:0] OFF_INTR   = 6'd20;
  localparam logic [5:0] OFF_INTE   = 6'd24;
  localparam logic [5:0] OFF_INTF   = 6'd28;
  localparam logic [5:0] OFF_INTS   = 6'd32;

  // width of the round-robin channel mask in CS
  localparam int unsigned RR_W = 5;

  // CS bit positions
  localparam int unsigned CS_ONESHOT    = 2;
  localparam int unsigned CS_MULTISHOT  = 3;
  localparam int unsigned CS_STICKY     = 10;
  localparam int unsigned CS_AINSEL_LO  = 12;
  localparam int unsigned CS_AINSEL_HI  = 14;
  localparam int unsigned CS_RR_LO      = 16;
  localparam int unsigned CS_RR_HI      = 20;

  // FCS bit positions
  localparam int unsigned FCS_UFLOW     = 10;
  localparam int unsigned FCS_OFLOW     = 11;
  localparam int unsigned FCS_THRESH_LO = 24;
  localparam int unsigned FCS_THRESH_HI = 27;

  // classified request kind
  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WRITE,
    KIND_DONE,
    KIND_NOP
  } kind_t;

  // decoded register target
  typedef enum logic [3:0] {
    REG_CS,
    REG_RESULT,
    REG_FCS,
    REG_FIFO,
    REG_DIV,
    REG_INTR,
    REG_INTE,
    REG_INTF,
    REG_INTS,
    REG_NONE
  } reg_sel_t;

  // one classified request as it travels through the queue
  typedef struct packed {
    kind_t       kind;
    reg_sel_t    sel;
    logic [31:0] wdata;
    logic [11:0] sample;
    logic        sample_err;
  } item_t;

endpackage : adcrr_pkg

`default_nettype wire

// ===== src/adcrr_front.sv =====
// ----------------------------------------------------------------------------
// adcrr_front
// Classifies an incoming request: op kind and decoded register target.
// ----------------------------------------------------------------------------
`default_nettype none

module adcrr_front
  import adcrr_pkg::*;
(
  input  wire logic [1:0]  op,
  input  wire logic [5:0]  reg_offset,
  input  wire logic [31:0] write_data,
  input  wire logic [11:0] sample,
  input  wire logic        sample_error,
  output item_t            item
);

  kind_t    kind;
  reg_sel_t sel;

  // op decode
  always_comb begin
    case (op)
      OP_READ:  kind = KIND_READ;
      OP_WRITE: kind = KIND_WRITE;
      OP_DONE:  kind = KIND_DONE;
      default:  kind = KIND_NOP;
    endcase
  end

  // register decode, unaligned and unmapped offsets go nowhere
  always_comb begin
    case (reg_offset)
      OFF_CS:     sel = REG_CS;
      OFF_RESULT: sel = REG_RESULT;
      OFF_FCS:    sel = REG_FCS;
      OFF_FIFO:   sel = REG_FIFO;
      OFF_DIV:    sel = REG_DIV;
      OFF_INTR:   sel = REG_INTR;
      OFF_INTE:   sel = REG_INTE;
      OFF_INTF:   sel = REG_INTF;
      OFF_INTS:   sel = REG_INTS;
      default:    sel = REG_NONE;
    endcase
  end

  assign item.kind       = kind;
  assign item.sel        = sel;
  assign item.wdata      = write_data;
  assign item.sample     = sample;
  assign item.sample_err = sample_error;

endmodule : adcrr_front

`default_nettype wire

// ===== src/adcrr_queue.sv =====
// ----------------------------------------------------------------------------
// adcrr_queue
// Two-entry request queue between the front end and the register back end.
// ----------------------------------------------------------------------------
`default_nettype none

module adcrr_queue
  import adcrr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       valid,
  output item_t      head_item
);

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign valid     = (cnt_r != 2'd0);
  assign head_item = slot_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_push_empty: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == 2'd0 && push) |=> valid)
    else $error("request lost after push into empty queue");

endmodule : adcrr_queue

`default_nettype wire

// ===== src/adcrr_back.sv =====
// ----------------------------------------------------------------------------
// adcrr_back
// Register file, result FIFO, round-robin channel advance and the result
// register that drives the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module adcrr_back
  import adcrr_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH   = 4,
  parameter int unsigned NUM_CHANNELS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        req_valid,
  input  wire item_t       req_item,
  output logic             req_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_start_conversion,
  output logic [2:0]       out_conversion_channel,
  output logic             out_interrupt,
  output logic             out_dma_request
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  // control/status fields
  logic [3:0]      cs_ctl_r,  cs_ctl_nxt;
  logic            err_r,     err_nxt;
  logic            sticky_r,  sticky_nxt;
  logic [2:0]      ainsel_r,  ainsel_nxt;
  logic [RR_W-1:0] rrobin_r,  rrobin_nxt;
  // fifo control fields
  logic [3:0]      fcs_ctl_r, fcs_ctl_nxt;
  logic            under_r,   under_nxt;
  logic            over_r,    over_nxt;
  logic [3:0]      thresh_r,  thresh_nxt;
  // other registers
  logic [23:0]     div_r,     div_nxt;
  logic            inte_r,    inte_nxt;
  logic            intf_r,    intf_nxt;
  logic            busy_r,    busy_nxt;
  logic [11:0]     last_r,    last_nxt;
  logic            dma_r,     dma_nxt;
  // result fifo
  logic [15:0]      fifo_mem_r [FIFO_DEPTH];
  logic [CNT_W-1:0] count_r,   count_nxt;
  logic [PTR_W-1:0] head_r,    head_nxt;
  logic [PTR_W-1:0] tail_r,    tail_nxt;
  logic             push_en;
  logic [15:0]      push_val;
  // result register
  logic        out_valid_r;
  logic [31:0] rd_r;
  logic        start_r;
  logic [2:0]  chan_r;
  logic        irq_r;
  logic        dma_out_r;
  logic [31:0] rd_nxt;
  logic        start_nxt;
  logic [2:0]  chan_nxt;
  logic        irq_nxt;
  // round robin
  logic [3:0]  rr_base;
  logic        rr_found;
  logic [2:0]  rr_chan;
  // derived
  logic        fifo_full;
  logic        fifo_empty;
  logic        raw_irq;
  logic [3:0]  level;

  assign fifo_full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign fifo_empty = (count_r == '0);
  assign level      = 4'(count_r);
  assign raw_irq    = (level >= thresh_r);

  // back end takes the next request whenever the result slot frees up
  assign req_pop = req_valid && (!out_valid_r || !out_stall);

  // next channel for round robin: start after AINSEL, first enabled below wrap
  always_comb begin
    logic [3:0] cand;
    rr_base = {1'b0, ainsel_r} + 4'd1;
    for (int i = 0; i < 8; i++) begin
      if (rr_base >= 4'(NUM_CHANNELS)) begin
        rr_base = rr_base - 4'(NUM_CHANNELS);
      end
    end
    rr_found = 1'b0;
    rr_chan  = ainsel_r;
    for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
      cand = rr_base + 4'(k);
      if (cand >= 4'(NUM_CHANNELS)) begin
        cand = cand - 4'(NUM_CHANNELS);
      end
      if (cand < 4'(RR_W) && rrobin_r[cand[2:0]]) begin
        rr_found = 1'b1;
        rr_chan  = cand[2:0];
      end
    end
  end

  // value pushed into the fifo on a completion
  always_comb begin
    push_val = fcs_ctl_r[1] ? {8'd0, req_item.sample[11:4]} : {4'd0, req_item.sample};
    push_val[15] = req_item.sample_err && fcs_ctl_r[2];
  end

  // request execution
  always_comb begin
    cs_ctl_nxt  = cs_ctl_r;
    err_nxt     = err_r;
    sticky_nxt  = sticky_r;
    ainsel_nxt  = ainsel_r;
    rrobin_nxt  = rrobin_r;
    fcs_ctl_nxt = fcs_ctl_r;
    under_nxt   = under_r;
    over_nxt    = over_r;
    thresh_nxt  = thresh_r;
    div_nxt     = div_r;
    inte_nxt    = inte_r;
    intf_nxt    = intf_r;
    busy_nxt    = busy_r;
    last_nxt    = last_r;
    dma_nxt     = dma_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    push_en     = 1'b0;
    rd_nxt      = 32'd0;
    start_nxt   = 1'b0;
    chan_nxt    = 3'd0;

    case (req_item.kind)
      KIND_READ: begin
        case (req_item.sel)
          REG_CS: begin
            rd_nxt = {11'd0, rrobin_r, 1'b0, ainsel_r, 1'b0, sticky_r, err_r, !busy_r,
                      4'd0, cs_ctl_r};
          end
          REG_RESULT: rd_nxt = {20'd0, last_r};
          REG_FCS: begin
            rd_nxt = {4'd0, thresh_r, 4'd0, level, 4'd0, over_r, under_r, fifo_full,
                      fifo_empty, 4'd0, fcs_ctl_r};
          end
          REG_FIFO: begin
            if (fifo_empty) begin
              under_nxt = 1'b1;
            end else begin
              rd_nxt    = {16'd0, fifo_mem_r[head_r]};
              count_nxt = count_r - CNT_W'(1);
              head_nxt  = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
              if (fcs_ctl_r[3]) begin
                dma_nxt = (4'(count_nxt) >= thresh_r);
              end
            end
          end
          REG_DIV:  rd_nxt = {8'd0, div_r};
          REG_INTR: rd_nxt = {31'd0, raw_irq};
          REG_INTE: rd_nxt = {31'd0, inte_r};
          REG_INTF: rd_nxt = {31'd0, intf_r};
          REG_INTS: rd_nxt = {31'd0, (raw_irq && inte_r) || intf_r};
          default:  rd_nxt = 32'd0;
        endcase
      end

      KIND_WRITE: begin
        case (req_item.sel)
          REG_CS: begin
            sticky_nxt = sticky_r && !req_item.wdata[CS_STICKY];
            cs_ctl_nxt = req_item.wdata[3:0];
            ainsel_nxt = req_item.wdata[CS_AINSEL_HI:CS_AINSEL_LO];
            rrobin_nxt = req_item.wdata[CS_RR_HI:CS_RR_LO];
            if (req_item.wdata[0] && !busy_r &&
                (req_item.wdata[CS_ONESHOT] || req_item.wdata[CS_MULTISHOT])) begin
              busy_nxt  = 1'b1;
              start_nxt = 1'b1;
              chan_nxt  = req_item.wdata[CS_AINSEL_HI:CS_AINSEL_LO];
            end
          end
          REG_FCS: begin
            over_nxt    = over_r && !req_item.wdata[FCS_OFLOW];
            under_nxt   = under_r && !req_item.wdata[FCS_UFLOW];
            fcs_ctl_nxt = req_item.wdata[3:0];
            thresh_nxt  = req_item.wdata[FCS_THRESH_HI:FCS_THRESH_LO];
          end
          REG_DIV:  div_nxt  = req_item.wdata[23:0];
          REG_INTE: inte_nxt = req_item.wdata[0];
          REG_INTF: intf_nxt = req_item.wdata[0];
          default: ;
        endcase
      end

      KIND_DONE: begin
        busy_nxt = 1'b0;
        last_nxt = req_item.sample;
        if (req_item.sample_err) begin
          err_nxt    = 1'b1;
          sticky_nxt = 1'b1;
        end else begin
          err_nxt = 1'b0;
        end
        if (fcs_ctl_r[0]) begin
          if (fifo_full) begin
            over_nxt = 1'b1;
          end else begin
            push_en   = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            tail_nxt  = (tail_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
            if (fcs_ctl_r[3]) begin
              dma_nxt = (4'(count_nxt) >= thresh_r);
            end
          end
        end
        if (rr_found) begin
          ainsel_nxt = rr_chan;
        end
        if (cs_ctl_r[CS_MULTISHOT]) begin
          busy_nxt  = 1'b1;
          start_nxt = 1'b1;
          chan_nxt  = ainsel_nxt;
        end
      end

      default: ;
    endcase

    irq_nxt = ((4'(count_nxt) >= thresh_nxt) && inte_nxt) || intf_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_ctl_r  <= '0;
      err_r     <= 1'b0;
      sticky_r  <= 1'b0;
      ainsel_r  <= '0;
      rrobin_r  <= '0;
      fcs_ctl_r <= '0;
      under_r   <= 1'b0;
      over_r    <= 1'b0;
      thresh_r  <= '0;
      div_r     <= '0;
      inte_r    <= 1'b0;
      intf_r    <= 1'b0;
      busy_r    <= 1'b0;
      last_r    <= '0;
      dma_r     <= 1'b0;
      count_r   <= '0;
      head_r    <= '0;
      tail_r    <= '0;
    end else if (req_pop) begin
      cs_ctl_r  <= cs_ctl_nxt;
      err_r     <= err_nxt;
      sticky_r  <= sticky_nxt;
      ainsel_r  <= ainsel_nxt;
      rrobin_r  <= rrobin_nxt;
      fcs_ctl_r <= fcs_ctl_nxt;
      under_r   <= under_nxt;
      over_r    <= over_nxt;
      thresh_r  <= thresh_nxt;
      div_r     <= div_nxt;
      inte_r    <= inte_nxt;
      intf_r    <= intf_nxt;
      busy_r    <= busy_nxt;
      last_r    <= last_nxt;
      dma_r     <= dma_nxt;
      count_r   <= count_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
    end
  end

  // fifo storage
  always_ff @(posedge clk) begin
    if (req_pop && push_en) begin
      fifo_mem_r[tail_r] <= push_val;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      rd_r      <= rd_nxt;
      start_r   <= start_nxt;
      chan_r    <= chan_nxt;
      irq_r     <= irq_nxt;
      dma_out_r <= dma_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_read_data          = rd_r;
  assign out_start_conversion   = start_r;
  assign out_conversion_channel = chan_r;
  assign out_interrupt          = irq_r;
  assign out_dma_request        = dma_out_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
      count_r <= CNT_W'(FIFO_DEPTH))
    else $error("fifo count above depth");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && start_r) |-> busy_r)
    else $error("start request without busy");
  a_dma_match: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> (dma_out_r == dma_r))
    else $error("dma output disagrees with latch");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_stall) |=> $stable(rd_r) && $stable(chan_r))
    else $error("stalled result changed");

endmodule : adcrr_back

`default_nettype wire

// ===== src/adc_controller_fifo_round_robin.sv =====
// A request is stored in the request queue, then its result in the result register.
// Throughput: one request per cycle while out_stall is low, limited only by the
// two-entry request queue and the single result register; in_stall rises only
// when the queue is full. Reset: synchronous, active low; clears the state registers,
// the queue and result valid; fifo entries stay as they are, never read before written.
// ----------------------------------------------------------------------------
// adc_controller_fifo_round_robin
// Register-level ADC controller with result fifo and round-robin channel
// advance: front decode, request queue, register back end.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_controller_fifo_round_robin
  import adcrr_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH   = 4,
  parameter int unsigned NUM_CHANNELS = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_op,
  input  wire logic [5:0]  in_reg_offset,
  input  wire logic [31:0] in_write_data,
  input  wire logic [11:0] in_sample,
  input  wire logic        in_sample_error,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_start_conversion,
  output logic [2:0]       out_conversion_channel,
  output logic             out_interrupt,
  output logic             out_dma_request
);

  item_t front_item;
  item_t head_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;
  logic  q_push;

  // request classification
  adcrr_front u_front (
    .op           (in_op),
    .reg_offset   (in_reg_offset),
    .write_data   (in_write_data),
    .sample       (in_sample),
    .sample_error (in_sample_error),
    .item         (front_item)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // request queue
  adcrr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_item (head_item)
  );

  // register back end
  adcrr_back #(
    .FIFO_DEPTH   (FIFO_DEPTH),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .req_valid              (q_valid),
    .req_item               (head_item),
    .req_pop                (q_pop),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_read_data          (out_read_data),
    .out_start_conversion   (out_start_conversion),
    .out_conversion_channel (out_conversion_channel),
    .out_interrupt          (out_interrupt),
    .out_dma_request        (out_dma_request)
  );

endmodule : adc_controller_fifo_round_robin

`default_nettype wire
